FILE: rtl/dcc_pkg.sv
// ============================================================================
// Distance clamp package
// Shared widths, beat types and clamp codes of the distance clamp core.
// ============================================================================
package dcc_pkg;

  localparam int unsigned CoordWidth   = 32;
  localparam int unsigned DistWidth    = CoordWidth - 1;
  localparam int unsigned ExtraBits    = 8;
  localparam int unsigned DiffWidth    = CoordWidth + 1;
  localparam int unsigned MagWidth     = DiffWidth;
  localparam int unsigned SqWidth      = 2 * MagWidth;
  localparam int unsigned BoundSqWidth = 2 * DistWidth;
  localparam int unsigned RadWidth     = SqWidth + 2 * ExtraBits;
  localparam int unsigned RootWidth    = RadWidth / 2;
  localparam int unsigned ProdWidth    = MagWidth + DistWidth;
  localparam int unsigned NumWidth     = ProdWidth + ExtraBits + 2;
  localparam int unsigned DenWidth     = RootWidth + 1;
  localparam int unsigned QuotWidth    = DistWidth;
  localparam int unsigned SumWidth     = CoordWidth + 2;

  typedef enum logic [1:0] {
    KindKeep = 2'd0,
    KindMax  = 2'd1,
    KindMin  = 2'd2,
    KindZero = 2'd3
  } clamp_kind_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] point_x;
    logic signed [CoordWidth-1:0] point_y;
    logic signed [CoordWidth-1:0] anchor_x;
    logic signed [CoordWidth-1:0] anchor_y;
    logic        [DistWidth-1:0]  min_distance;
    logic        [DistWidth-1:0]  max_dist;
  } in_beat_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] result_x;
    logic signed [CoordWidth-1:0] result_y;
    logic        [1:0]            clamp_kind;
  } out_beat_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] point_x;
    logic signed [CoordWidth-1:0] point_y;
    logic signed [CoordWidth-1:0] anchor_x;
    logic signed [CoordWidth-1:0] anchor_y;
    logic                         neg_x;
    logic                         neg_y;
    clamp_kind_e                  kind;
  } keep_t;

endpackage

FILE: rtl/distance_constraint_clamp_core.sv
// ============================================================================
// Distance clamp core
// Clamps a 2D point to a minimum and maximum distance around an anchor.
// ============================================================================
// One beat enters per cycle while in_stall_o is low, and every beat gives
// one result beat. A beat passes 80 register stages, the first loaded at the
// accepting edge: five stages for offset, squares and bound tests, 41 stages
// of the square root (one root bit each), one stage to form the numerator,
// 31 stages of the two dividers (one quotient bit each), and two stages for
// the final add and the output register.
// A skid register behind the output lets the pipeline take one more beat
// while a result is stalled; input stall rises only when that skid is full.
module distance_constraint_clamp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dcc_pkg::in_beat_t   in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dcc_pkg::out_beat_t  out_beat_o
);
  import dcc_pkg::*;

  localparam int unsigned SqLineDepth  = RootWidth - 1;
  localparam int unsigned DivLineDepth = QuotWidth;

  logic en;

  logic                        s1_valid_q;
  in_beat_t                    s1_beat_q;
  logic signed [DiffWidth-1:0] s1_dx_q, s1_dy_q;

  logic                    s2_valid_q;
  in_beat_t                s2_beat_q;
  logic [MagWidth-1:0]     s2_mag_x_q, s2_mag_y_q;
  logic                    s2_neg_x_q, s2_neg_y_q;
  logic [BoundSqWidth-1:0] s2_max_sq_q, s2_min_sq_q;

  logic                    s3_valid_q;
  in_beat_t                s3_beat_q;
  logic [MagWidth-1:0]     s3_mag_x_q, s3_mag_y_q;
  logic                    s3_neg_x_q, s3_neg_y_q;
  logic [BoundSqWidth-1:0] s3_max_sq_q, s3_min_sq_q;
  logic [SqWidth-1:0]      s3_sq_x_q, s3_sq_y_q;

  logic                    s4_valid_q;
  in_beat_t                s4_beat_q;
  logic [MagWidth-1:0]     s4_mag_x_q, s4_mag_y_q;
  logic                    s4_neg_x_q, s4_neg_y_q;
  logic [BoundSqWidth-1:0] s4_max_sq_q, s4_min_sq_q;
  logic [SqWidth-1:0]      s4_sum_q;

  clamp_kind_e         s5_kind_d;
  logic [DistWidth-1:0] s5_target_d;
  logic                s5_valid_q;
  keep_t               s5_keep_q;
  logic [MagWidth-1:0] s5_mag_x_q, s5_mag_y_q;
  logic [DistWidth-1:0] s5_target_q;
  logic [SqWidth-1:0]  s5_sum_q;

  logic                 s6_valid_q;
  keep_t                s6_keep_q;
  logic [ProdWidth-1:0] s6_prod_x_q, s6_prod_y_q;

  logic                 sq_valid_q  [SqLineDepth];
  keep_t                sq_keep_q   [SqLineDepth];
  logic [ProdWidth-1:0] sq_prod_x_q [SqLineDepth];
  logic [ProdWidth-1:0] sq_prod_y_q [SqLineDepth];
  logic [RootWidth-1:0] root;

  logic                s7_valid_q;
  keep_t               s7_keep_q;
  logic [NumWidth-1:0] s7_num_x_q, s7_num_y_q;
  logic [DenWidth-1:0] s7_den_q;

  logic                 dv_valid_q [DivLineDepth];
  keep_t                dv_keep_q  [DivLineDepth];
  logic [QuotWidth-1:0] quot_x, quot_y;

  logic                       s8_valid_q;
  clamp_kind_e                s8_kind_q;
  logic signed [SumWidth-1:0] s8_sum_x_q, s8_sum_y_q;
  logic signed [SumWidth-1:0] sum_x_d, sum_y_d;

  out_beat_t last_beat;
  logic      out_valid_q, skid_valid_q, pop;
  out_beat_t out_beat_q, skid_beat_q;

  function automatic logic signed [CoordWidth-1:0] sat_coord(
    input logic signed [SumWidth-1:0] v
  );
    logic signed [SumWidth-1:0] hi;
    logic signed [SumWidth-1:0] lo;
    hi = SumWidth'({1'b0, {(CoordWidth-1){1'b1}}});
    lo = -hi - SumWidth'(1);
    if (v > hi) return hi[CoordWidth-1:0];
    if (v < lo) return lo[CoordWidth-1:0];
    return v[CoordWidth-1:0];
  endfunction

  function automatic logic signed [SumWidth-1:0] place(
    input logic signed [CoordWidth-1:0] base,
    input logic                         neg,
    input logic [QuotWidth-1:0]         q
  );
    logic signed [SumWidth-1:0] ext;
    logic signed [SumWidth-1:0] off;
    ext = SumWidth'(base);
    off = $signed(SumWidth'(q));
    return neg ? (ext - off) : (ext + off);
  endfunction

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // Stage 1: offsets
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_beat_q <= in_beat_i;
      s1_dx_q   <= DiffWidth'(in_beat_i.point_x) - DiffWidth'(in_beat_i.anchor_x);
      s1_dy_q   <= DiffWidth'(in_beat_i.point_y) - DiffWidth'(in_beat_i.anchor_y);
    end
  end

  // Stage 2: magnitudes and bound squares
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_beat_q   <= s1_beat_q;
      s2_neg_x_q  <= s1_dx_q[DiffWidth-1];
      s2_neg_y_q  <= s1_dy_q[DiffWidth-1];
      s2_mag_x_q  <= s1_dx_q[DiffWidth-1] ? MagWidth'(-s1_dx_q) : MagWidth'(s1_dx_q);
      s2_mag_y_q  <= s1_dy_q[DiffWidth-1] ? MagWidth'(-s1_dy_q) : MagWidth'(s1_dy_q);
      s2_max_sq_q <= BoundSqWidth'(s1_beat_q.max_dist) *
                     BoundSqWidth'(s1_beat_q.max_dist);
      s2_min_sq_q <= BoundSqWidth'(s1_beat_q.min_distance) *
                     BoundSqWidth'(s1_beat_q.min_distance);
    end
  end

  // Stage 3: offset squares
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_beat_q   <= s2_beat_q;
      s3_mag_x_q  <= s2_mag_x_q;
      s3_mag_y_q  <= s2_mag_y_q;
      s3_neg_x_q  <= s2_neg_x_q;
      s3_neg_y_q  <= s2_neg_y_q;
      s3_max_sq_q <= s2_max_sq_q;
      s3_min_sq_q <= s2_min_sq_q;
      s3_sq_x_q   <= SqWidth'(s2_mag_x_q) * SqWidth'(s2_mag_x_q);
      s3_sq_y_q   <= SqWidth'(s2_mag_y_q) * SqWidth'(s2_mag_y_q);
    end
  end

  // Stage 4: squared length
  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_beat_q   <= s3_beat_q;
      s4_mag_x_q  <= s3_mag_x_q;
      s4_mag_y_q  <= s3_mag_y_q;
      s4_neg_x_q  <= s3_neg_x_q;
      s4_neg_y_q  <= s3_neg_y_q;
      s4_max_sq_q <= s3_max_sq_q;
      s4_min_sq_q <= s3_min_sq_q;
      s4_sum_q    <= s3_sq_x_q + s3_sq_y_q;
    end
  end

  // Stage 5: classify, zero first, then maximum before minimum
  always_comb begin
    s5_kind_d   = KindKeep;
    s5_target_d = '0;
    if (s4_sum_q == '0) begin
      s5_kind_d = KindZero;
    end else if (s4_sum_q > SqWidth'(s4_max_sq_q)) begin
      s5_kind_d   = KindMax;
      s5_target_d = s4_beat_q.max_dist;
    end else if (s4_sum_q < SqWidth'(s4_min_sq_q)) begin
      s5_kind_d   = KindMin;
      s5_target_d = s4_beat_q.min_distance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_keep_q.point_x  <= s4_beat_q.point_x;
      s5_keep_q.point_y  <= s4_beat_q.point_y;
      s5_keep_q.anchor_x <= s4_beat_q.anchor_x;
      s5_keep_q.anchor_y <= s4_beat_q.anchor_y;
      s5_keep_q.neg_x    <= s4_neg_x_q;
      s5_keep_q.neg_y    <= s4_neg_y_q;
      s5_keep_q.kind     <= s5_kind_d;
      s5_mag_x_q         <= s4_mag_x_q;
      s5_mag_y_q         <= s4_mag_y_q;
      s5_target_q        <= s5_target_d;
      s5_sum_q           <= s4_sum_q;
    end
  end

  // Stage 6: scaled magnitudes
  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_keep_q   <= s5_keep_q;
      s6_prod_x_q <= ProdWidth'(s5_mag_x_q) * ProdWidth'(s5_target_q);
      s6_prod_y_q <= ProdWidth'(s5_mag_y_q) * ProdWidth'(s5_target_q);
    end
  end

  dcc_sqrt_pipe u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({s5_sum_q, {(2*ExtraBits){1'b0}}}),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_keep_q[0]   <= s6_keep_q;
      sq_prod_x_q[0] <= s6_prod_x_q;
      sq_prod_y_q[0] <= s6_prod_y_q;
      for (int i = 1; i < SqLineDepth; i++) begin
        sq_keep_q[i]   <= sq_keep_q[i-1];
        sq_prod_x_q[i] <= sq_prod_x_q[i-1];
        sq_prod_y_q[i] <= sq_prod_y_q[i-1];
      end
    end
  end

  // Stage 7: rounded numerators and divisor
  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_keep_q  <= sq_keep_q[SqLineDepth-1];
      s7_num_x_q <= NumWidth'({sq_prod_x_q[SqLineDepth-1], {(ExtraBits+1){1'b0}}}) +
                    NumWidth'(root);
      s7_num_y_q <= NumWidth'({sq_prod_y_q[SqLineDepth-1], {(ExtraBits+1){1'b0}}}) +
                    NumWidth'(root);
      s7_den_q   <= {root, 1'b0};
    end
  end

  dcc_div_pipe u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (s7_num_x_q),
    .den_i  (s7_den_q),
    .quot_o (quot_x)
  );

  dcc_div_pipe u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (s7_num_y_q),
    .den_i  (s7_den_q),
    .quot_o (quot_y)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_keep_q[0] <= s7_keep_q;
      for (int i = 1; i < DivLineDepth; i++) begin
        dv_keep_q[i] <= dv_keep_q[i-1];
      end
    end
  end

  // Stage 8: place along the offset
  always_comb begin
    keep_t k;
    k = dv_keep_q[DivLineDepth-1];
    if (k.kind == KindMax || k.kind == KindMin) begin
      sum_x_d = place(k.anchor_x, k.neg_x, quot_x);
      sum_y_d = place(k.anchor_y, k.neg_y, quot_y);
    end else begin
      sum_x_d = SumWidth'(k.point_x);
      sum_y_d = SumWidth'(k.point_y);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_kind_q  <= dv_keep_q[DivLineDepth-1].kind;
      s8_sum_x_q <= sum_x_d;
      s8_sum_y_q <= sum_y_d;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
      s7_valid_q <= 1'b0;
      s8_valid_q <= 1'b0;
      for (int i = 0; i < SqLineDepth; i++) sq_valid_q[i] <= 1'b0;
      for (int i = 0; i < DivLineDepth; i++) dv_valid_q[i] <= 1'b0;
    end else if (en) begin
      s1_valid_q    <= in_valid_i;
      s2_valid_q    <= s1_valid_q;
      s3_valid_q    <= s2_valid_q;
      s4_valid_q    <= s3_valid_q;
      s5_valid_q    <= s4_valid_q;
      s6_valid_q    <= s5_valid_q;
      sq_valid_q[0] <= s6_valid_q;
      for (int i = 1; i < SqLineDepth; i++) sq_valid_q[i] <= sq_valid_q[i-1];
      s7_valid_q    <= sq_valid_q[SqLineDepth-1];
      dv_valid_q[0] <= s7_valid_q;
      for (int i = 1; i < DivLineDepth; i++) dv_valid_q[i] <= dv_valid_q[i-1];
      s8_valid_q    <= dv_valid_q[DivLineDepth-1];
    end
  end

  // Output register and skid
  assign last_beat.result_x   = sat_coord(s8_sum_x_q);
  assign last_beat.result_y   = sat_coord(s8_sum_y_q);
  assign last_beat.clamp_kind = s8_kind_q;
  assign pop                  = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_valid_q <= s8_valid_q;
    end else if (s8_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_beat_q <= skid_beat_q;
      end
    end else if (!out_valid_q || pop) begin
      out_beat_q <= last_beat;
    end else if (s8_valid_q) begin
      skid_beat_q <= last_beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat while output register is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled without an output stall");

  a_clamp_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s5_valid_q && (s5_keep_q.kind == KindMax || s5_keep_q.kind == KindMin))
      |-> (s5_sum_q != '0))
    else $error("clamp selected for a zero-length offset");

  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s8_valid_q && !en) |=> (s8_valid_q && $stable(s8_sum_x_q) && $stable(s8_sum_y_q)))
    else $error("last stage changed while the pipeline was held");
`endif

endmodule

FILE: rtl/dcc_sqrt_pipe.sv
// ============================================================================
// Pipelined square root
// Restoring integer square root, one root bit per register stage.
// ============================================================================
module dcc_sqrt_pipe (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [dcc_pkg::RadWidth-1:0]   rad_i,
  output logic [dcc_pkg::RootWidth-1:0]  root_o
);
  import dcc_pkg::*;

  localparam int unsigned RemWidth = RootWidth + 2;

  logic [RemWidth-1:0]  rem_q  [RootWidth];
  logic [RootWidth-1:0] root_q [RootWidth];
  logic [RadWidth-1:0]  rad_q  [RootWidth];

  for (genvar k = 0; k < RootWidth; k++) begin : g_step
    logic [RemWidth-1:0]  rem_cur;
    logic [RootWidth-1:0] root_cur;
    logic [RadWidth-1:0]  rad_cur;
    logic [RemWidth-1:0]  rem_in;
    logic [RemWidth-1:0]  trial;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_cur  = '0;
      assign root_cur = '0;
      assign rad_cur  = rad_i;
    end else begin : g_next
      assign rem_cur  = rem_q[k-1];
      assign root_cur = root_q[k-1];
      assign rad_cur  = rad_q[k-1];
    end

    assign rem_in = {rem_cur[RemWidth-3:0], rad_cur[RadWidth-1 -: 2]};
    assign trial  = {root_cur, 2'b01};
    assign ge     = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rem_in - trial) : rem_in;
        root_q[k] <= {root_cur[RootWidth-2:0], ge};
        rad_q[k]  <= {rad_cur[RadWidth-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[RootWidth-1];

endmodule

FILE: rtl/dcc_div_pipe.sv
// ============================================================================
// Pipelined divider
// Restoring unsigned division, one quotient bit per register stage.
// ============================================================================
module dcc_div_pipe (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [dcc_pkg::NumWidth-1:0]  num_i,
  input  logic [dcc_pkg::DenWidth-1:0]  den_i,
  output logic [dcc_pkg::QuotWidth-1:0] quot_o
);
  import dcc_pkg::*;

  logic [DenWidth-1:0]  rem_q  [QuotWidth];
  logic [DenWidth-1:0]  den_q  [QuotWidth];
  logic [QuotWidth-1:0] low_q  [QuotWidth];
  logic [QuotWidth-1:0] quot_q [QuotWidth];

  for (genvar k = 0; k < QuotWidth; k++) begin : g_step
    logic [DenWidth-1:0]  rem_cur;
    logic [DenWidth-1:0]  den_cur;
    logic [QuotWidth-1:0] low_cur;
    logic [QuotWidth-1:0] quot_cur;
    logic [DenWidth:0]    rem_in;
    logic [DenWidth:0]    diff;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_cur  = num_i[QuotWidth+DenWidth-1:QuotWidth];
      assign den_cur  = den_i;
      assign low_cur  = num_i[QuotWidth-1:0];
      assign quot_cur = '0;
    end else begin : g_next
      assign rem_cur  = rem_q[k-1];
      assign den_cur  = den_q[k-1];
      assign low_cur  = low_q[k-1];
      assign quot_cur = quot_q[k-1];
    end

    assign rem_in = {rem_cur, low_cur[QuotWidth-1]};
    assign ge     = (rem_in >= {1'b0, den_cur});
    assign diff   = rem_in - {1'b0, den_cur};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DenWidth-1:0] : rem_in[DenWidth-1:0];
        den_q[k]  <= den_cur;
        low_q[k]  <= {low_cur[QuotWidth-2:0], 1'b0};
        quot_q[k] <= {quot_cur[QuotWidth-2:0], ge};
      end
    end
  end

  assign quot_o = quot_q[QuotWidth-1];

endmodule

FILE: sim/tb_top.sv
// ============================================================================
// Distance clamp core testbench
// Drives point/anchor/bound beats through the core and compares each result
// beat with an internal prediction of the clamp, including saturation.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;
  import dcc_pkg::*;

  localparam int NumRandom = 650;
  localparam int Latency   = 80;

  typedef struct {
    in_beat_t  stim;
    logic      has_exp;
    out_beat_t exp;
  } row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_beat_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_beat_o;

  out_beat_t clamp_expected_q[$];
  int        mismatches;
  bit        stim_done;
  bit        hold_off;

  distance_constraint_clamp_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [255:0] isqrt(logic [255:0] x);
    logic [255:0] r;
    logic [255:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (256'd1 << b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [CoordWidth-1:0] saturate(logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (CoordWidth - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[CoordWidth-1:0];
    if (v < lo) return lo[CoordWidth-1:0];
    return v[CoordWidth-1:0];
  endfunction

  function automatic logic signed [127:0] stretch(logic signed [127:0] d,
                                                  logic [255:0] target,
                                                  logic [255:0] len);
    logic [255:0] mag;
    logic [255:0] q;
    mag = 256'((d < 0) ? -d : d);
    q = (((mag * target) << (ExtraBits + 1)) + len) / (len << 1);
    return (d < 0) ? -$signed({1'b0, q[126:0]}) : $signed({1'b0, q[126:0]});
  endfunction

  function automatic out_beat_t clamp_point(in_beat_t b);
    logic signed [127:0] px, py, ax, ay, dx, dy, rx, ry;
    logic [255:0] sq, mx, mn, len, target;
    clamp_kind_e kind;
    out_beat_t o;
    px = 128'(b.point_x);  py = 128'(b.point_y);
    ax = 128'(b.anchor_x); ay = 128'(b.anchor_y);
    dx = px - ax;    dy = py - ay;
    sq = ((dx < 0) ? -dx : dx) * ((dx < 0) ? -dx : dx)
       + ((dy < 0) ? -dy : dy) * ((dy < 0) ? -dy : dy);
    mx = 256'(b.max_dist);
    mn = 256'(b.min_distance);
    rx = px; ry = py;
    target = '0;
    if (sq == 0) kind = KindZero;
    else if (sq > mx * mx) begin
      kind = KindMax; target = mx;
    end else if (sq < mn * mn) begin
      kind = KindMin; target = mn;
    end else kind = KindKeep;
    if (kind == KindMax || kind == KindMin) begin
      len = isqrt(sq << (2 * ExtraBits));
      rx = ax + stretch(dx, target, len);
      ry = ay + stretch(dy, target, len);
    end
    o.result_x = saturate(rx);
    o.result_y = saturate(ry);
    o.clamp_kind = kind;
    return o;
  endfunction

  function automatic in_beat_t mk(int px, int py, int ax, int ay, int mn, int mx);
    in_beat_t b;
    b.point_x = px; b.point_y = py; b.anchor_x = ax; b.anchor_y = ay;
    b.min_distance = mn[DistWidth-1:0];
    b.max_dist     = mx[DistWidth-1:0];
    return b;
  endfunction

  function automatic out_beat_t res(int rx, int ry, clamp_kind_e k);
    out_beat_t o;
    o.result_x = rx; o.result_y = ry; o.clamp_kind = k;
    return o;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 20) - 10;
      2: return 32'sh7fff_ffff - $urandom_range(0, 1000);
      3: return 32'sh8000_0000 + $urandom_range(0, 1000);
      default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic in_beat_t rand_beat();
    in_beat_t b;
    int ax, ay, r;
    ax = rand_coord(); ay = rand_coord();
    b.anchor_x = ax; b.anchor_y = ay;
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 32'h0040_0000);
      b.point_x = ax + $signed($urandom_range(0, 2 * r)) - r;
      b.point_y = ay + $signed($urandom_range(0, 2 * r)) - r;
      b.min_distance = DistWidth'($urandom_range(0, 32'h0040_0000));
      b.max_dist     = DistWidth'($urandom_range(0, 32'h0060_0000));
    end else begin
      b.point_x = rand_coord(); b.point_y = rand_coord();
      b.min_distance = DistWidth'($urandom); b.max_dist = DistWidth'($urandom);
    end
    if ($urandom_range(0, 19) == 0) b.point_x = b.anchor_x;
    if ($urandom_range(0, 29) == 0) begin
      b.point_x = b.anchor_x; b.point_y = b.anchor_y;
    end
    return b;
  endfunction

  task automatic send(in_beat_t b);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    clamp_expected_q.push_back(clamp_point(b));
    @(negedge clk_i);
  endtask

  task automatic check(out_beat_t exp, out_beat_t act);
    if (exp !== act) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp x=%h y=%h k=%0d act x=%h y=%h k=%0d",
                 exp.result_x, exp.result_y, exp.clamp_kind,
                 act.result_x, act.result_y, act.clamp_kind);
    end
  endtask

  initial begin
    row_t rows[$];
    row_t r;
    int   m;
    m = 32'h7fff_ffff;
    in_valid_i = 1'b0;
    in_beat_i  = '0;
    rst_ni     = 1'b0;
    mismatches = 0;
    stim_done  = 1'b0;
    hold_off   = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    rows.push_back('{mk(5, 7, 5, 7, 10, 0), 1, res(5, 7, KindZero)});
    rows.push_back('{mk(0, 0, 0, 0, 0, 0), 1, res(0, 0, KindZero)});
    rows.push_back('{mk(30, 40, 0, 0, 10, 100), 1, res(30, 40, KindKeep)});
    rows.push_back('{mk(300, 400, 0, 0, 10, 50), 1, res(30, 40, KindMax)});
    rows.push_back('{mk(3, 4, 0, 0, 50, 100), 1, res(30, 40, KindMin)});
    rows.push_back('{mk(3, 4, 0, 0, 50, 1), 1, res(1, 1, KindMax)});
    rows.push_back('{mk(3, 4, 0, 0, 50, 5), 1, res(30, 40, KindMin)});
    rows.push_back('{mk(-300, -400, 0, 0, 0, 5), 1, res(-3, -4, KindMax)});
    rows.push_back('{mk(10, 0, 0, 0, m, m), 1, res(m, 0, KindMin)});
    rows.push_back('{mk(-10, 0, 0, 0, m, m), 0, '0});
    rows.push_back('{mk(m, m, 32'sh8000_0000, 32'sh8000_0000, 0, m), 0, '0});
    rows.push_back('{mk(32'sh8000_0000, m, m, 32'sh8000_0000, 0, 0), 0, '0});
    rows.push_back('{mk(m, 0, m - 1, 0, m, m), 0, '0});
    rows.push_back('{mk(32'sh8000_0000, 0, 32'sh8000_0001, 0, m, m), 0, '0});
    rows.push_back('{mk(1, 1, 0, 0, 1, 1), 0, '0});
    rows.push_back('{mk(m, m, m, m, m, 0), 1, res(m, m, KindZero)});
    rows.push_back('{mk(12345, -6789, -100, 2000, 7, 3), 0, '0});
    foreach (rows[i]) begin
      r = rows[i];
      if (r.has_exp) check(r.exp, clamp_point(r.stim));
      send(r.stim);
    end
    for (int i = 0; i < NumRandom; i++) begin
      if (i == 300) hold_off = 1'b1;
      send(rand_beat());
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int gap;
    bit held;
    out_stall_i = 1'b0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (300) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
        out_stall_i <= 1'b1;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (clamp_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat x=%h", out_beat_o.result_x);
      end else begin
        check(clamp_expected_q.pop_front(), out_beat_o);
      end
    end
  end

  initial begin
    wait (stim_done);
    while (clamp_expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
